### hdl/tsp_pkg.sv
// Package for the trapezoid speed profile block.
// Holds register indexes, reset values, phase codes and shared widths.
// Used by tsp_divider and trapezoid_speed_profile.
package tsp_pkg;

    // Width of the speed fields and of the configuration write data.
    localparam int SPEED_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Default for the TIME_BITS parameter of the top level.
    localparam int TIME_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL   = 2'd3;

    // Register values after reset.
    localparam logic [CFG_W-1:0] TARGET_RST = 16'd1000;
    localparam logic [CFG_W-1:0] RISE_RST   = 16'd100;
    localparam logic [CFG_W-1:0] HOLD_RST   = 16'd150;
    localparam logic [CFG_W-1:0] FALL_RST   = 16'd100;

    // Phase codes on the result.
    localparam logic [1:0] PH_RISE = 2'd0;
    localparam logic [1:0] PH_HOLD = 2'd1;
    localparam logic [1:0] PH_FALL = 2'd2;

endpackage

### hdl/tsp_divider.sv
// Bit-serial restoring divider for the trapezoid speed profile block.
// Produces a SPEED_W-bit quotient, one bit per cycle; depends on tsp_pkg.
module tsp_divider
    import tsp_pkg::*;
#(
    parameter int TW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SPEED_W+TW-1:0] i_dividend,
    input  logic [TW-1:0]         i_divisor,
    output logic                  o_busy,
    output logic [SPEED_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(SPEED_W + 1);

    logic [TW-1:0]      r_rem;
    logic [SPEED_W-1:0] r_dvd;
    logic [TW-1:0]      r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;

    logic [TW:0]   trial;
    logic          fits;
    logic [TW:0]   diff;

    // The dividend is known to be below divisor * 2^SPEED_W, so the upper
    // part starts below the divisor and the quotient fits SPEED_W bits.
    always_comb begin
        trial = {r_rem, r_dvd[SPEED_W-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(SPEED_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[SPEED_W+TW-1:SPEED_W];
            r_dvd <= i_dividend[SPEED_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[TW-1:0] : trial[TW-1:0];
            r_dvd <= {r_dvd[SPEED_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_dvd;

endmodule

### hdl/trapezoid_speed_profile.sv
// Top level of the periodic trapezoidal speed profile generator.
// Depends on tsp_pkg and instantiates tsp_divider.
//
// Usage: every item on the input channel (i_in_valid / o_in_ready) is one
// publish tick and carries a restart flag that puts the cycle position back
// to zero before the tick is evaluated. For every item the block returns
// exactly one item on the output channel (o_out_valid / i_out_ready) with
// the commanded speed in signed mm/s and the phase (rising, holding,
// falling). The ramp value is a product of the plateau speed and a tick
// count, divided by the ramp length and truncated toward zero.
// The phase and operands are registered at the accepting edge. The
// multiplier then registers the product in ST_MUL, ST_LOAD loads the
// divider, the bit-serial divider works through the quotient in ST_DIV,
// the sequencer sees the divider finish and moves to ST_DONE, and ST_DONE
// writes the output register and raises o_out_valid.
// The serial divider handles one item at a time; a new item is taken only
// once the last is through, as o_in_ready is high only while the sequencer
// is idle, which it is again in the cycle after the result is written.
// The output register holds a finished item while the receiver stalls, and
// the next item can already be taken and worked on meanwhile; a new result
// waits in the sequencer until the output register frees up.
// Reset (synchronous, active low) restores the default profile (1000 mm/s,
// 100 / 150 / 100 ticks), clears the position and empties the output.
// Configuration writes are taken on any cycle with i_cfg_we high.
module trapezoid_speed_profile
    import tsp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SPEED_W-1:0]   o_speed,
    output logic [1:0]                  o_phase
);

    // Tick registers keep only the low TIME_BITS bits of a 16-bit write.
    localparam int TW = (TIME_BITS < CFG_W) ? TIME_BITS : CFG_W;
    // Position counter width; a full cycle is below 2^(TW+2).
    localparam int PW = TIME_BITS + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state;

    // Configuration.
    logic signed [SPEED_W-1:0] r_target;
    logic [TW-1:0]             r_rise;
    logic [TW-1:0]             r_hold;
    logic [TW-1:0]             r_fall;

    // Cycle position.
    logic [PW-1:0] r_pos;

    // Operands and results of the current item.
    logic [SPEED_W-1:0]    r_mag;
    logic [TW-1:0]         r_mult;
    logic [TW-1:0]         r_divisor;
    logic                  r_neg;
    logic [1:0]            r_phase;
    logic [SPEED_W+TW-1:0] r_prod;

    // Output register.
    logic                      r_out_valid;
    logic signed [SPEED_W-1:0] r_speed;
    logic [1:0]                r_phase_out;

    logic                  in_fire;
    logic                  out_free;
    logic [PW-1:0]         period;
    logic [PW-1:0]         pos;
    logic [PW-1:0]         t;
    logic [PW-1:0]         rise_hold;
    logic [PW-1:0]         d;
    logic [PW-1:0]         t_next;
    logic [1:0]            n_phase;
    logic [TW-1:0]         n_mult;
    logic [TW-1:0]         n_divisor;
    logic [SPEED_W-1:0]    target_mag;
    logic                  div_busy;
    logic [SPEED_W-1:0]    quotient;
    logic [SPEED_W-1:0]    n_speed;

    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // Phase selection and operand setup for the tick being accepted. The
    // plateau and the empty falling ramp use a divisor of one so that the
    // same multiply and divide path yields the plateau speed or zero.
    always_comb begin
        period     = PW'(r_rise) + PW'(r_hold) + PW'(r_fall);
        pos        = i_restart ? '0 : r_pos;
        t          = (pos >= period) ? '0 : pos;
        rise_hold  = PW'(r_rise) + PW'(r_hold);
        d          = t - rise_hold;
        target_mag = r_target[SPEED_W-1] ? SPEED_W'(-r_target) : SPEED_W'(r_target);
        if (t < PW'(r_rise)) begin
            n_phase   = PH_RISE;
            n_mult    = t[TW-1:0];
            n_divisor = r_rise;
        end else if (t < rise_hold) begin
            n_phase   = PH_HOLD;
            n_mult    = TW'(1);
            n_divisor = TW'(1);
        end else if (r_fall != '0) begin
            n_phase   = PH_FALL;
            n_mult    = r_fall - d[TW-1:0];
            n_divisor = r_fall;
        end else begin
            n_phase   = PH_FALL;
            n_mult    = '0;
            n_divisor = TW'(1);
        end
        t_next = t + 1'b1;
        if (t_next >= period) begin
            t_next = '0;
        end
    end

    assign n_speed = r_neg ? SPEED_W'(-quotient) : quotient;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_rise   <= RISE_RST[TW-1:0];
            r_hold   <= HOLD_RST[TW-1:0];
            r_fall   <= FALL_RST[TW-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET: r_target <= i_cfg_data;
                REG_RISE:   r_rise   <= i_cfg_data[TW-1:0];
                REG_HOLD:   r_hold   <= i_cfg_data[TW-1:0];
                REG_FALL:   r_fall   <= i_cfg_data[TW-1:0];
                default:    r_target <= r_target;
            endcase
        end
    end

    // Sequencer, position counter and output register. A result written in
    // ST_DONE replaces the one being taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_pos   <= t_next;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (!div_busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mag     <= target_mag;
            r_neg     <= r_target[SPEED_W-1];
            r_mult    <= n_mult;
            r_divisor <= n_divisor;
            r_phase   <= n_phase;
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_mag * r_mult;
        end
        if (r_state == ST_DONE && out_free) begin
            r_speed     <= n_speed;
            r_phase_out <= r_phase;
        end
    end

    tsp_divider #(
        .TW (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_LOAD),
        .i_dividend (r_prod),
        .i_divisor  (r_divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_speed     = r_speed;
    assign o_phase     = r_phase_out;

endmodule

### test/tsp_profile_checker.sv
// Result checker for the trapezoid speed profile block.
// Mirrors the profile registers and the cycle position from the ports and
// compares each output item in order. Depends on tsp_pkg.
module tsp_profile_checker
    import tsp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_restart,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [SPEED_W-1:0] i_speed,
    input  logic [1:0]                i_phase,
    output int                        o_fail_cnt,
    output int                        o_pending,
    output int                        o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [1:0]                phase;
    } t_speed_point;

    t_speed_point want_q[$];

    // Profile registers and position, held as wide integers for the arithmetic.
    longint plateau  = 1000;
    longint rise_len = 100;
    longint hold_len = 150;
    longint fall_len = 100;
    longint cyc_pos  = 0;

    int bad_cnt = 0;
    int got_cnt = 0;

    // Speed and phase for one tick; advances the cycle position.
    function automatic t_speed_point profile_point(input logic restart_bit);
        longint span;
        longint pos;
        longint quo;
        t_speed_point pt;
        span = rise_len + hold_len + fall_len;
        if (restart_bit) cyc_pos = 0;
        // A position left outside a shrunk cycle counts as zero.
        pos = (cyc_pos >= span) ? 0 : cyc_pos;
        if (pos < rise_len) begin
            quo = (plateau * pos) / rise_len;
            pt.phase = PH_RISE;
        end else if (pos < rise_len + hold_len) begin
            quo = plateau;
            pt.phase = PH_HOLD;
        end else if (fall_len != 0) begin
            quo = (plateau * (fall_len - (pos - rise_len - hold_len))) / fall_len;
            pt.phase = PH_FALL;
        end else begin
            // Only an empty cycle lands here.
            quo = 0;
            pt.phase = PH_FALL;
        end
        pt.speed = quo[SPEED_W-1:0];
        pos++;
        if (pos >= span) pos = 0;
        cyc_pos = pos;
        return pt;
    endfunction

    always @(posedge i_clk) begin : watch
        t_speed_point got;
        t_speed_point want;
        if (!i_rst_n) begin
            plateau  = longint'($signed(TARGET_RST));
            rise_len = longint'(RISE_RST);
            hold_len = longint'(HOLD_RST);
            fall_len = longint'(FALL_RST);
            cyc_pos  = 0;
            want_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.speed = i_speed;
                got.phase = i_phase;
                got_cnt++;
                if (want_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("[%0t] result %0d with no tick outstanding: %0d phase %0d",
                                 $realtime, got_cnt, got.speed, got.phase);
                end else begin
                    want = want_q.pop_front();
                    if (got.speed !== want.speed || got.phase !== want.phase) begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display("[%0t] result %0d: speed exp %0d got %0d,",
                                     $realtime, got_cnt, want.speed, got.speed,
                                     " phase exp %0d got %0d", want.phase, got.phase);
                    end
                end
            end
            // A tick taken at this edge still sees the profile from before
            // a write at the same edge.
            if (i_in_valid && i_in_ready)
                want_q.push_back(profile_point(i_restart));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET: plateau  = longint'($signed(i_cfg_data));
                    REG_RISE:   rise_len = longint'(i_cfg_data);
                    REG_HOLD:   hold_len = longint'(i_cfg_data);
                    REG_FALL:   fall_len = longint'(i_cfg_data);
                    default: ;
                endcase
            end
        end
        o_pending  <= want_q.size();
        o_fail_cnt <= bad_cnt;
        o_results  <= got_cnt;
    end

endmodule

### test/tb.sv
// Top of the testbench for trapezoid_speed_profile.
// Drives ticks, profile writes and output back-pressure; tsp_profile_checker
// judges the results. Depends on tsp_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsp_pkg::*;

    localparam int RAND_TICKS   = 550;
    localparam int LONG_HOLD    = 300;      // cycles of the one long output stall
    localparam int DRAIN_CYCLES = 40;       // extra wait for stray results after the drain
    localparam int QUIET_TAIL   = 80;       // last random ticks run without idling

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_idx    = '0;
    logic [CFG_W-1:0]          cfg_data   = '0;
    logic                      in_valid   = 1'b0;
    logic                      restart    = 1'b0;
    logic                      out_ready  = 1'b0;
    logic                      in_ready;
    logic                      out_valid;
    logic signed [SPEED_W-1:0] speed;
    logic [1:0]                phase;

    int fail_cnt;
    int pending;
    int results;

    // Idling switches for the two sides, and the request for the long stall.
    bit tx_gaps       = 1'b0;
    bit rx_gaps       = 1'b0;
    bit hold_off_req  = 1'b0;
    bit hold_off_seen = 1'b0;

    int ticks_sent = 0;
    int profiles   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    trapezoid_speed_profile u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_restart  (restart),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_speed    (speed),
        .o_phase    (phase)
    );

    tsp_profile_checker u_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_restart  (restart),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_speed    (speed),
        .i_phase    (phase),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_results  (results)
    );

    // Offers one publish tick and returns at the edge where it is taken.
    // Valid is left high on return, so a following tick keeps it up without
    // a drop; the drop only happens when a gap or a drain follows.
    task automatic offer_tick(input logic restart_bit);
        int gap;
        if (tx_gaps && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_bit;
        do @(posedge clk); while (!(in_valid && in_ready));
        ticks_sent++;
    endtask

    // Stops offering and waits until every tick has produced its result.
    // The pending count is a registered copy of the checker's queue size.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Writes all four profile registers on consecutive edges. Only called
    // while the block is idle.
    task automatic load_profile(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] rise,
                                input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] fall);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_TARGET;
        cfg_data <= tgt;
        @(posedge clk);
        cfg_idx  <= REG_RISE;
        cfg_data <= rise;
        @(posedge clk);
        cfg_idx  <= REG_HOLD;
        cfg_data <= hold;
        @(posedge clk);
        cfg_idx  <= REG_FALL;
        cfg_data <= fall;
        @(posedge clk);
        cfg_we   <= 1'b0;
        profiles++;
    endtask

    // Ramp and plateau lengths: mostly short so that every phase and the
    // wrap come around often, with zero, full scale and mid-size values
    // mixed in.
    function automatic logic [CFG_W-1:0] pick_span();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            3:       return 16'($urandom_range(9, 300));
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // Receiver side. Ready drops in short random bursts while rx_gaps is
    // set, and once in the run it stays low for the one long stall so that the
    // output register and the sequencer both fill and input ready drops.
    initial begin : rx_side
        int burst;
        @(posedge clk);
        forever begin
            if (hold_off_req && !hold_off_seen) begin
                hold_off_seen = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 5);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin : tx_side
        int seg_len;
        int rand_sent;
        logic [CFG_W-1:0] tgt;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side.
        // Reset profile: first tick restarts, the next two ramp up from 0.
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b0);
        settle();

        // Largest positive plateau with a tiny cycle: rise, hold and the first
        // fall tick. The position is left at four.
        load_profile(16'h7FFF, 16'd2, 16'd1, 16'd2);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b0);
        offer_tick(1'b0);
        settle();

        // No fall and a cycle of two: the position of four lies outside the
        // shrunk cycle and is taken as zero, then the cycle wraps.
        load_profile(16'd7, 16'd2, 16'd0, 16'd0);
        offer_tick(1'b0);
        offer_tick(1'b0);
        offer_tick(1'b0);
        settle();

        // No rise: the cycle opens on the plateau, then falls.
        load_profile(16'hFFFB, 16'd0, 16'd1, 16'd2);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b0);
        settle();

        // Empty cycle: speed 0 in the fall phase, position stuck at 0.
        load_profile(16'h8000, 16'd0, 16'd0, 16'd0);
        offer_tick(1'b0);
        offer_tick(1'b1);
        settle();

        // Most negative plateau on the longest ramps.
        load_profile(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_tick(1'b1);
        offer_tick(1'b0);

        // Random part: segments of ticks, each under a fresh profile. The
        // position carries over between segments unless a restart clears it,
        // so shrunk cycles come up on their own.
        rand_sent = 0;
        while (rand_sent < RAND_TICKS) begin
            settle();
            case ($urandom_range(0, 9))
                0:       tgt = 16'h7FFF;
                1:       tgt = 16'h8000;
                default: tgt = 16'($urandom);
            endcase
            load_profile(tgt, pick_span(), pick_span(), pick_span());

            seg_len = $urandom_range(15, 45);
            if (RAND_TICKS - rand_sent <= QUIET_TAIL) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end else begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            // Halfway through, the receiver stalls for a long stretch while
            // this segment keeps offering ticks.
            if (!hold_off_req && rand_sent >= RAND_TICKS / 2) begin
                hold_off_req = 1'b1;
                seg_len = 40;
            end
            repeat (seg_len) begin
                offer_tick($urandom_range(0, 15) == 0);
                rand_sent++;
            end
        end

        // Drain, then allow time for any stray result to show up.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d ticks under %0d profiles, %0d results compared,",
                 ticks_sent, profiles, results);
        $display("including zero ramps, an empty cycle and a %0d-cycle output stall.",
                 LONG_HOLD);
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASS trapezoid_speed_profile");
        end else begin
            $display("FAIL trapezoid_speed_profile");
        end
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial begin
        #5_000_000;
        $display("FAIL trapezoid_speed_profile");
        $finish;
    end

endmodule
